// ----- rtl/core/femr_pkg.sv -----
// ----------------------------------------------------------------------------
// femr_pkg: shared types and constants of the filled ellipse rasterizer
// Command and status bundles between controller and datapath, operation codes
// of the shared multiplier and of the decision update, and result selectors.
// ----------------------------------------------------------------------------
package femr_pkg;

    // Default geometry widths
    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    // Input item kinds
    localparam logic KIND_START = 1'b0;

    // Result primitive kinds
    localparam logic PRIM_SPAN  = 1'b0;
    localparam logic PRIM_POINT = 1'b1;

    // Operand pairs of the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,     // a * a        -> a2
        MUL_BB,     // b * b        -> b2
        MUL_A2B,    // a2 * b       -> t1
        MUL_STEP1,  // b2 * (2x+3) or b2 * (2x+2)  -> t1
        MUL_STEP2,  // a2 * (2-2y) or a2 * (3-2y)  -> t2
        MUL_TST1,   // b2 * (x+1)   -> t1
        MUL_TST2,   // a2 * (2y-1)  -> t2
        MUL_SQX,    // (2x+1)^2     -> t1
        MUL_SQY,    // (y-1)^2      -> t2
        MUL_B2T1,   // b2 * t1      -> t1
        MUL_A2T2,   // a2 * t2      -> t2
        MUL_A2B2    // a2 * b2      -> t3
    } mul_op_t;

    // Decision variable updates
    typedef enum logic [1:0] {
        D_NONE,
        D_START,
        D_STEP,
        D_SWITCH
    } d_op_t;

    // Result selectors, in output order
    localparam int EMIT_SEL_BITS = 3;
    typedef enum logic [EMIT_SEL_BITS-1:0] {
        E_SPAN_UP,
        E_SPAN_DN,
        E_PT_PP,
        E_PT_PM,
        E_PT_MM,
        E_PT_MP
    } emit_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        mul_op_t   mul_op;
        d_op_t     d_op;
        logic      fin;
        logic      emit;
        emit_sel_t emit_sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic active;
        logic region_two;
        logic switch_due;
        logic out_free;
    } status_t;

endpackage

// ----- rtl/core/femr_ctrl.sv -----
// ----------------------------------------------------------------------------
// femr_ctrl: sequencer of the filled ellipse rasterizer
// Takes input words, steps the datapath through the multiplier schedule of
// one iteration and releases the six result words of the item.
// ----------------------------------------------------------------------------
module femr_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_kind,
    input  femr_pkg::status_t status,
    output femr_pkg::cmd_t    cmd
);
    import femr_pkg::*;

    typedef enum logic [18:0] {
        S_IDLE   = 19'h00001,
        S_AA     = 19'h00002,
        S_BB     = 19'h00004,
        S_A2B    = 19'h00008,
        S_DSTART = 19'h00010,
        S_STEP1  = 19'h00020,
        S_STEP2  = 19'h00040,
        S_DSTEP  = 19'h00080,
        S_TST1   = 19'h00100,
        S_TST2   = 19'h00200,
        S_CHECK  = 19'h00400,
        S_SQX    = 19'h00800,
        S_SQY    = 19'h01000,
        S_B2T1   = 19'h02000,
        S_A2T2   = 19'h04000,
        S_A2B2   = 19'h08000,
        S_DSW    = 19'h10000,
        S_FIN    = 19'h20000,
        S_EMIT   = 19'h40000
    } state_t;

    state_t    state_reg, state_next;
    emit_sel_t idx_reg, idx_next;

    // Next state and command decode
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.emit_sel = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_kind == KIND_START) begin
                        cmd.load   = 1'b1;
                        state_next = S_AA;
                    end else if (status.active) begin
                        state_next = S_STEP1;
                    end
                end
            end
            S_AA: begin
                cmd.mul_op = MUL_AA;
                state_next = S_BB;
            end
            S_BB: begin
                cmd.mul_op = MUL_BB;
                state_next = S_A2B;
            end
            S_A2B: begin
                cmd.mul_op = MUL_A2B;
                state_next = S_DSTART;
            end
            S_DSTART: begin
                cmd.d_op   = D_START;
                state_next = S_TST1;
            end
            S_STEP1: begin
                cmd.mul_op = MUL_STEP1;
                state_next = S_STEP2;
            end
            S_STEP2: begin
                cmd.mul_op = MUL_STEP2;
                state_next = S_DSTEP;
            end
            S_DSTEP: begin
                cmd.d_op   = D_STEP;
                state_next = status.region_two ? S_FIN : S_TST1;
            end
            S_TST1: begin
                cmd.mul_op = MUL_TST1;
                state_next = S_TST2;
            end
            S_TST2: begin
                cmd.mul_op = MUL_TST2;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                state_next = status.switch_due ? S_SQX : S_FIN;
            end
            S_SQX: begin
                cmd.mul_op = MUL_SQX;
                state_next = S_SQY;
            end
            S_SQY: begin
                cmd.mul_op = MUL_SQY;
                state_next = S_B2T1;
            end
            S_B2T1: begin
                cmd.mul_op = MUL_B2T1;
                state_next = S_A2T2;
            end
            S_A2T2: begin
                cmd.mul_op = MUL_A2T2;
                state_next = S_A2B2;
            end
            S_A2B2: begin
                cmd.mul_op = MUL_A2B2;
                state_next = S_DSW;
            end
            S_DSW: begin
                cmd.d_op   = D_SWITCH;
                state_next = S_FIN;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                idx_next   = E_SPAN_UP;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                // hand one result word to the output register when it has room
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (idx_reg == E_PT_MP) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = emit_sel_t'(idx_reg + 1'b1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= E_SPAN_UP;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- rtl/core/femr_dpath.sv -----
// ----------------------------------------------------------------------------
// femr_dpath: datapath of the filled ellipse rasterizer
// Holds the walk state, one shared multiplier with product registers, the
// decision update, the result geometry and the output register.
// ----------------------------------------------------------------------------
module femr_dpath #(
    parameter int COORD_BITS  = femr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = femr_pkg::RADIUS_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  femr_pkg::cmd_t                cmd,
    output femr_pkg::status_t             status,
    input  logic signed [COORD_BITS-1:0]  in_center_x,
    input  logic signed [COORD_BITS-1:0]  in_center_y,
    input  logic [RADIUS_BITS-1:0]        in_radius_x,
    input  logic [RADIUS_BITS-1:0]        in_radius_y,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_prim_kind,
    output logic signed [COORD_BITS:0]    out_x_left,
    output logic signed [COORD_BITS:0]    out_x_right,
    output logic signed [COORD_BITS:0]    out_row,
    output logic                          out_last,
    output logic                          out_done
);
    import femr_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int R  = RADIUS_BITS;
    localparam int S  = R + 1;          // quadrant point
    localparam int O  = C + 1;          // result coordinates
    localparam int AW = 2 * R;          // unsigned multiplier operand
    localparam int BW = 2 * R + 6;      // signed multiplier operand
    localparam int PW = AW + 1 + BW;    // product
    localparam int DW = 4 * R + 8;      // decision variable

    // Walk state
    logic signed [C-1:0]  cx_reg, cy_reg;
    logic [R-1:0]         a_reg, b_reg;
    logic [AW-1:0]        a2_reg, b2_reg;
    logic [S-1:0]         x_reg, y_reg;
    logic signed [DW-1:0] d_reg, t1_reg, t2_reg, t3_reg;
    logic                 region_two_reg, active_reg, near_reg, done_reg;

    // Output register
    logic                 out_valid_reg, out_kind_reg, out_last_reg, out_done_reg;
    logic signed [O-1:0]  out_xl_reg, out_xr_reg, out_row_reg;

    // Multiplier
    logic [AW-1:0]        mul_a;
    logic signed [BW-1:0] mul_b, x_b, y_b;
    logic [S:0]           x2p1;
    logic [S-1:0]         ym1;
    logic signed [PW-1:0] prod;
    logic signed [DW-1:0] prod_d;

    // Decision update
    logic signed [DW-1:0] a2_d, b2_d, t1x4, t2x4, t3x4, step_inc;
    logic signed [DW-1:0] d_start, d_switch;
    logic                 branch, finish;
    logic [S-1:0]         x_step, y_step;

    // Result geometry
    logic signed [O-1:0]  cxo, cyo, xo, yo, row_up, row_dn;
    logic                 res_kind;
    logic signed [O-1:0]  res_xl, res_xr, res_row;
    logic                 out_free;

    // Select multiplier operands
    always_comb begin
        x_b  = BW'(x_reg);
        y_b  = BW'(y_reg);
        x2p1 = {x_reg, 1'b1};
        ym1  = (y_reg == '0) ? S'(1) : y_reg - S'(1);
        unique case (cmd.mul_op)
            MUL_AA: begin
                mul_a = AW'(a_reg);
                mul_b = BW'(a_reg);
            end
            MUL_BB: begin
                mul_a = AW'(b_reg);
                mul_b = BW'(b_reg);
            end
            MUL_A2B: begin
                mul_a = a2_reg;
                mul_b = BW'(b_reg);
            end
            MUL_STEP1: begin
                mul_a = b2_reg;
                mul_b = x_b + x_b + (region_two_reg ? BW'(2) : BW'(3));
            end
            MUL_STEP2: begin
                mul_a = a2_reg;
                mul_b = (region_two_reg ? BW'(3) : BW'(2)) - y_b - y_b;
            end
            MUL_TST1: begin
                mul_a = b2_reg;
                mul_b = x_b + BW'(1);
            end
            MUL_TST2: begin
                mul_a = a2_reg;
                mul_b = y_b + y_b - BW'(1);
            end
            MUL_SQX: begin
                mul_a = AW'(x2p1);
                mul_b = BW'(x2p1);
            end
            MUL_SQY: begin
                mul_a = AW'(ym1);
                mul_b = BW'(ym1);
            end
            MUL_B2T1: begin
                mul_a = b2_reg;
                mul_b = t1_reg[BW-1:0];
            end
            MUL_A2T2: begin
                mul_a = a2_reg;
                mul_b = t2_reg[BW-1:0];
            end
            MUL_A2B2: begin
                mul_a = a2_reg;
                mul_b = BW'(b2_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod   = $signed({1'b0, mul_a}) * mul_b;
        prod_d = {{(DW - PW){prod[PW-1]}}, prod};
    end

    // Work out the decision step, the region test and the new point
    always_comb begin
        a2_d     = DW'(a2_reg);
        b2_d     = DW'(b2_reg);
        t1x4     = t1_reg <<< 2;
        t2x4     = t2_reg <<< 2;
        t3x4     = t3_reg <<< 2;
        branch   = region_two_reg ? (d_reg <= 0) : (d_reg < 0);
        if (region_two_reg) begin
            step_inc = branch ? (t1x4 + t2x4) : t2x4;
        end else begin
            step_inc = branch ? t1x4 : (t1x4 + t2x4);
        end
        x_step   = (!region_two_reg || branch) ? x_reg + S'(1) : x_reg;
        y_step   = (region_two_reg || !branch) ? y_reg - S'(1) : y_reg;
        d_start  = (b2_d <<< 2) - t1x4 + a2_d;
        d_switch = t1_reg + t2x4 - t3x4;
        finish   = region_two_reg && (y_reg == '0);
        out_free = !out_valid_reg || out_ready;
    end

    // Form the selected result word
    always_comb begin
        cxo    = {cx_reg[C-1], cx_reg};
        cyo    = {cy_reg[C-1], cy_reg};
        xo     = O'(x_reg);
        yo     = O'(y_reg);
        row_up = near_reg ? cyo + yo : cyo + yo - O'(1);
        row_dn = near_reg ? cyo - yo : cyo - yo + O'(1);
        unique case (cmd.emit_sel)
            E_SPAN_UP: begin
                res_kind = PRIM_SPAN;
                res_xl   = cxo - xo;
                res_xr   = cxo + xo;
                res_row  = row_up;
            end
            E_SPAN_DN: begin
                res_kind = PRIM_SPAN;
                res_xl   = cxo - xo;
                res_xr   = cxo + xo;
                res_row  = row_dn;
            end
            E_PT_PP: begin
                res_kind = PRIM_POINT;
                res_xl   = cxo + xo;
                res_xr   = cxo + xo;
                res_row  = cyo + yo;
            end
            E_PT_PM: begin
                res_kind = PRIM_POINT;
                res_xl   = cxo + xo;
                res_xr   = cxo + xo;
                res_row  = cyo - yo;
            end
            E_PT_MM: begin
                res_kind = PRIM_POINT;
                res_xl   = cxo - xo;
                res_xr   = cxo - xo;
                res_row  = cyo - yo;
            end
            E_PT_MP: begin
                res_kind = PRIM_POINT;
                res_xl   = cxo - xo;
                res_xr   = cxo - xo;
                res_row  = cyo + yo;
            end
            default: begin
                res_kind = PRIM_SPAN;
                res_xl   = '0;
                res_xr   = '0;
                res_row  = '0;
            end
        endcase
    end

    // Control state: activity, region and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            region_two_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.load) begin
                active_reg     <= 1'b1;
                region_two_reg <= 1'b0;
            end else if (cmd.d_op == D_SWITCH) begin
                region_two_reg <= 1'b1;
            end
            if (cmd.fin && finish) begin
                active_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: loaded ellipse, products, decision and point
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= in_center_x;
            cy_reg <= in_center_y;
            a_reg  <= in_radius_x;
            b_reg  <= in_radius_y;
            x_reg  <= '0;
            y_reg  <= S'(in_radius_y);
        end
        case (cmd.mul_op)
            MUL_AA:                                        a2_reg <= prod[AW-1:0];
            MUL_BB:                                        b2_reg <= prod[AW-1:0];
            MUL_A2B, MUL_STEP1, MUL_TST1, MUL_SQX, MUL_B2T1: t1_reg <= prod_d;
            MUL_STEP2, MUL_TST2, MUL_SQY, MUL_A2T2:        t2_reg <= prod_d;
            MUL_A2B2:                                      t3_reg <= prod_d;
            default: ;
        endcase
        unique case (cmd.d_op)
            D_START: begin
                d_reg    <= d_start;
                near_reg <= 1'b0;
            end
            D_STEP: begin
                d_reg    <= d_reg + step_inc;
                x_reg    <= x_step;
                y_reg    <= y_step;
                near_reg <= region_two_reg && (y_step <= S'(1));
            end
            D_SWITCH: begin
                d_reg <= d_switch;
            end
            default: ;
        endcase
        if (cmd.fin) begin
            done_reg <= finish;
        end
        if (cmd.emit) begin
            out_kind_reg <= res_kind;
            out_xl_reg   <= res_xl;
            out_xr_reg   <= res_xr;
            out_row_reg  <= res_row;
            out_last_reg <= (cmd.emit_sel == E_PT_MP);
            out_done_reg <= done_reg;
        end
    end

    assign status.active     = active_reg;
    assign status.region_two = region_two_reg;
    assign status.switch_due = !region_two_reg && !((t1_reg <<< 1) < t2_reg);
    assign status.out_free   = out_free;

    assign out_valid     = out_valid_reg;
    assign out_prim_kind = out_kind_reg;
    assign out_x_left    = out_xl_reg;
    assign out_x_right   = out_xr_reg;
    assign out_row       = out_row_reg;
    assign out_last      = out_last_reg;
    assign out_done      = out_done_reg;

endmodule

// ----- rtl/core/filled_ellipse_midpoint_rasterizer.sv -----
// ----------------------------------------------------------------------------
// filled_ellipse_midpoint_rasterizer: midpoint ellipse fill and outline
// Input word on s_*: tuser is the kind (0 start, 1 advance); tdata carries
// centre and radii, read on a start only. Each start, and each advance while
// an ellipse is in progress, yields six words on m_*: two fill spans, then
// four mirrored outline points. tlast marks the sixth word; tuser[1] is set
// on all six words of the item that completes the ellipse. An advance with
// no ellipse in progress is taken and yields nothing.
// Timing: the block takes no new input word until all six result words of
// the item have gone to the output register. A start, an advance in region
// one, an advance in region two and an item that moves the walk into region
// two each take their own path through the schedule. The pace is set by one
// shared multiplier, used once per cycle through the schedule of the
// decision update and region test, and by the six-word output sequence.
// The output register lets the next input word be taken while the last
// result word still waits. When the receiver stalls the sequence halts on
// the held word; nothing is lost. Reset drops any ellipse in progress and
// empties the output register; the block is ready once reset is released.
// ----------------------------------------------------------------------------
module filled_ellipse_midpoint_rasterizer #(
    parameter int COORD_BITS  = femr_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = femr_pkg::RADIUS_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, radius_x, radius_y, zero padding
    input  logic [((2*COORD_BITS+2*RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // kind
    input  logic s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // x_left, x_right, row, zero padding
    output logic [((3*(COORD_BITS+1)+7)/8)*8-1:0] m_tdata,
    // prim_kind, done_res
    output logic [1:0] m_tuser,
    output logic m_tlast
);
    import femr_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int R       = RADIUS_BITS;
    localparam int OUT_TDW = ((3 * (C + 1) + 7) / 8) * 8;

    cmd_t    cmd;
    status_t status;

    logic                signed_kind_unused;
    logic                out_prim_kind, out_last, out_done;
    logic signed [C:0]   out_x_left, out_x_right, out_row;

    assign signed_kind_unused = s_tuser;

    femr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (signed_kind_unused),
        .status   (status),
        .cmd      (cmd)
    );

    femr_dpath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .in_center_x   (s_tdata[C-1:0]),
        .in_center_y   (s_tdata[2*C-1:C]),
        .in_radius_x   (s_tdata[2*C+R-1:2*C]),
        .in_radius_y   (s_tdata[2*C+2*R-1:2*C+R]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_prim_kind (out_prim_kind),
        .out_x_left    (out_x_left),
        .out_x_right   (out_x_right),
        .out_row       (out_row),
        .out_last      (out_last),
        .out_done      (out_done)
    );

    // Pack the result word
    assign m_tdata = OUT_TDW'({out_row, out_x_right, out_x_left});
    assign m_tuser = {out_done, out_prim_kind};
    assign m_tlast = out_last;

endmodule

// ----- verif/ellipse_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// ellipse_scoreboard_pkg: result prediction for the filled ellipse rasterizer
// Holds a cycle-free model of the midpoint ellipse walk. Every accepted input
// word is stepped through the model and, unless it is an advance with no walk
// in progress, the six resulting primitives are queued. Output words are then
// compared field by field in arrival order.
package ellipse_scoreboard_pkg;

    import femr_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int RB = RADIUS_BITS_DEF;
    localparam int OW = CB + 1;

    typedef struct packed {
        logic          prim_kind;
        logic [OW-1:0] x_left;
        logic [OW-1:0] x_right;
        logic [OW-1:0] row;
        logic          last_of_item;
        logic          done_res;
    } ellipse_word_t;

    class ellipse_scoreboard;
        // Walk state
        longint pos_x, pos_y, dvar;
        longint ctr_x, ctr_y, rad_a, rad_b;
        bit     in_region_two, busy;
        ellipse_word_t awaited[$];
        int     mismatches;

        function new();
            pos_x = 0; pos_y = 0; dvar = 0;
            ctr_x = 0; ctr_y = 0; rad_a = 0; rad_b = 0;
            in_region_two = 0; busy = 0;
            mismatches = 0;
        endfunction

        function bit walking();
            return busy;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function ellipse_word_t make_word(logic prim, longint xl, longint xr, longint yrow);
            ellipse_word_t w;
            w.prim_kind    = prim;
            w.x_left       = xl[OW-1:0];
            w.x_right      = xr[OW-1:0];
            w.row          = yrow[OW-1:0];
            w.last_of_item = 1'b0;
            w.done_res     = 1'b0;
            return w;
        endfunction

        // Step the walk for one accepted word; returns the number of words queued
        function int note_item(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                               logic [RB-1:0] rx, logic [RB-1:0] ry);
            longint a2, b2, up, dn;
            bit finished;
            ellipse_word_t w [6];
            if (kind == KIND_START) begin
                ctr_x = longint'($signed(cx));
                ctr_y = longint'($signed(cy));
                rad_a = longint'(rx);
                rad_b = longint'(ry);
            end else if (!busy) begin
                return 0;
            end
            a2 = rad_a * rad_a;
            b2 = rad_b * rad_b;
            if (kind == KIND_START) begin
                pos_x = 0;
                pos_y = rad_b;
                dvar = rad_b * (4 * rad_b - 4 * a2) + a2;
                in_region_two = 0;
                busy = 1;
            end else if (!in_region_two) begin
                if (dvar < 0) begin
                    dvar += 4 * (b2 * (2 * pos_x + 3));
                end else begin
                    dvar += 4 * (b2 * (2 * pos_x + 3) + a2 * (2 - 2 * pos_y));
                    pos_y -= 1;
                end
                pos_x += 1;
            end else begin
                if (dvar <= 0) begin
                    dvar += 4 * (b2 * (2 * pos_x + 2) + a2 * (3 - 2 * pos_y));
                    pos_x += 1;
                end else begin
                    dvar += 4 * a2 * (3 - 2 * pos_y);
                end
                pos_y -= 1;
            end

            // Spans hug the outline rows once the walk is about to close
            up = pos_y - 1;
            dn = 1 - pos_y;
            if (in_region_two && pos_y - 1 <= 0) begin
                up = pos_y;
                dn = -pos_y;
            end
            w[0] = make_word(PRIM_SPAN, ctr_x - pos_x, ctr_x + pos_x, ctr_y + up);
            w[1] = make_word(PRIM_SPAN, ctr_x - pos_x, ctr_x + pos_x, ctr_y + dn);
            w[2] = make_word(PRIM_POINT, ctr_x + pos_x, ctr_x + pos_x, ctr_y + pos_y);
            w[3] = make_word(PRIM_POINT, ctr_x + pos_x, ctr_x + pos_x, ctr_y - pos_y);
            w[4] = make_word(PRIM_POINT, ctr_x - pos_x, ctr_x - pos_x, ctr_y - pos_y);
            w[5] = make_word(PRIM_POINT, ctr_x - pos_x, ctr_x - pos_x, ctr_y + pos_y);
            w[5].last_of_item = 1'b1;

            // Switch region when the slope passes -1, then test for the end
            if (!in_region_two && !(b2 * 2 * (pos_x + 1) < a2 * (2 * pos_y - 1))) begin
                dvar = b2 * (4 * pos_x * pos_x + 4 * pos_x + 1)
                     + a2 * (4 * pos_y * pos_y - 8 * pos_y + 4) - 4 * a2 * b2;
                in_region_two = 1;
            end
            finished = in_region_two && pos_y <= 0;
            if (finished)
                busy = 0;
            foreach (w[k]) begin
                w[k].done_res = finished;
                awaited.push_back(w[k]);
            end
            return 6;
        endfunction

        function void compare_field(string name, longint want, longint seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
                mismatches++;
            end
        endfunction

        // Compare one output word against the oldest queued one
        function void check_word(ellipse_word_t got);
            ellipse_word_t want;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            compare_field("prim_kind", want.prim_kind, got.prim_kind);
            compare_field("x_left", $signed(want.x_left), $signed(got.x_left));
            compare_field("x_right", $signed(want.x_right), $signed(got.x_right));
            compare_field("row", $signed(want.row), $signed(got.row));
            compare_field("last_of_item", want.last_of_item, got.last_of_item);
            compare_field("done_res", want.done_res, got.done_res);
        endfunction
    endclass

endpackage

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stream-level check of the filled ellipse rasterizer
// Drives start and advance words with random gaps while the result side
// stalls at random. A directed opening covers extreme centres and radii,
// degenerate axes, idle advances and restarts; random ellipses, mostly small
// and walked to completion, follow. Every result word is checked in order.
// ----------------------------------------------------------------------------
module testbench;

    import femr_pkg::*;
    import ellipse_scoreboard_pkg::*;

    localparam int IN_W   = ((2 * CB + 2 * RB + 7) / 8) * 8;
    localparam int OUT_DW = ((3 * OW + 7) / 8) * 8;
    localparam logic KIND_ADVANCE = ~KIND_START;
    localparam int TARGET_ITEMS = 320;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 40;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_DW-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    ellipse_scoreboard sb;
    ellipse_word_t     seen_word;
    bit                no_idle = 0;
    int                items_with_words = 0;
    int                stalled_cycles = 0;

    filled_ellipse_midpoint_rasterizer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Mostly no pause, often a short one, now and then a long one
    function automatic int pick_pause();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    // Offer one word on the input side and hold it until taken
    task automatic send_item(logic kind, logic [CB-1:0] cx, logic [CB-1:0] cy,
                             logic [RB-1:0] rx, logic [RB-1:0] ry);
        int gap;
        logic [IN_W-1:0] word;
        gap = pick_pause();
        word = '0;
        word[2*CB+2*RB-1:0] = {ry, rx, cy, cx};
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_item(kind, cx, cy, rx, ry) > 0)
            items_with_words++;
    endtask

    task automatic send_advance();
        send_item(KIND_ADVANCE, CB'($urandom), CB'($urandom), RB'($urandom), RB'($urandom));
    endtask

    // Step the current ellipse until it closes or the cap is reached
    task automatic walk_ellipse(int cap);
        int n;
        n = 0;
        while (sb.walking() && n < cap) begin
            send_advance();
            n++;
        end
    endtask

    // Hold the input side until every queued word has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    // One random ellipse: mostly small and complete, a few large and cut short
    task automatic random_ellipse();
        int r, cap;
        logic [RB-1:0] rx, ry;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            rx = RB'($urandom_range(0, 14));
            ry = RB'($urandom_range(0, 14));
            cap = 200;
        end else if (r < 92) begin
            rx = RB'($urandom_range(0, 80));
            ry = RB'($urandom_range(0, 80));
            cap = 40;
        end else begin
            rx = RB'($urandom_range(0, 1023));
            ry = RB'($urandom_range(0, 1023));
            cap = 12;
        end
        // Break off some walks so the next start drops them
        if ($urandom_range(0, 9) == 0)
            cap = $urandom_range(1, 5);
        send_item(KIND_START, CB'($urandom), CB'($urandom), rx, ry);
        walk_ellipse(cap);
        // Stray advances, ignored once the ellipse has closed
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_advance();
    endtask

    // Result side: random backpressure
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            n = pick_pause();
            if (n == 0) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
        end
    end

    // Check every word taken from the result side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_word.prim_kind    = m_tuser[0];
            seen_word.x_left       = m_tdata[OW-1:0];
            seen_word.x_right      = m_tdata[2*OW-1:OW];
            seen_word.row          = m_tdata[3*OW-1:2*OW];
            seen_word.last_of_item = m_tlast;
            seen_word.done_res     = m_tuser[1];
            sb.check_word(seen_word);
        end
    end

    // Abort when neither side has moved a word for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Main sequence
    initial begin
        int ellipses;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Advance with nothing in progress
        send_advance();
        // Zero vertical axis closes on the start word
        send_item(KIND_START, -12'sd2048, -12'sd2048, 10'd5, 10'd0);
        send_advance();
        // Zero horizontal axis goes straight to region two
        send_item(KIND_START, 12'sd2047, 12'sd2047, 10'd0, 10'd2);
        walk_ellipse(10);
        // Largest radii, then a restart over the running walk
        send_item(KIND_START, 12'sd2047, -12'sd2048, 10'd1023, 10'd1023);
        walk_ellipse(3);
        send_item(KIND_START, 12'sd0, 12'sd0, 10'd3, 10'd2);
        walk_ellipse(20);
        // Very flat and very tall shapes
        send_item(KIND_START, -12'sd2048, 12'sd2047, 10'd1023, 10'd1);
        walk_ellipse(2);
        send_item(KIND_START, 12'sd1, -12'sd1, 10'd1, 10'd1023);
        walk_ellipse(2);
        // Unit circle to completion, then an advance after the end
        send_item(KIND_START, -12'sd1, 12'sd1, 10'd1, 10'd1);
        walk_ellipse(10);
        send_advance();
        drain_results();

        // Random ellipses, some phases free of gaps and stalls
        ellipses = 0;
        while (items_with_words < TARGET_ITEMS) begin
            no_idle = ($urandom_range(0, 4) == 0);
            random_ellipse();
            ellipses++;
            if (ellipses % 6 == 0)
                drain_results();
        end
        no_idle = 0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
